// ===== rtl/btpc_pkg.sv =====
// Package: shared types, constants and helpers of the barometric compensation block.
package btpc_pkg;

    localparam int DivBits = 32;

    localparam logic [31:0] Recip100 = 32'h51EB851F;  // x/100 == (x*Recip100)>>37, x < 2^32
    localparam int Recip100Shift = 37;

    localparam logic [3:0] CFG_T1    = 4'd0;
    localparam logic [3:0] CFG_T2    = 4'd1;
    localparam logic [3:0] CFG_T3    = 4'd2;
    localparam logic [3:0] CFG_P1    = 4'd3;
    localparam logic [3:0] CFG_P2_P3 = 4'd4;
    localparam logic [3:0] CFG_P4_P5 = 4'd5;
    localparam logic [3:0] CFG_P6_P7 = 4'd6;
    localparam logic [3:0] CFG_P8_P9 = 4'd7;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
    } in_word_t;

    typedef struct packed {
        logic signed [7:0] temp_deg;
        logic [15:0]       press_hpa;
        logic              div_zero;
    } out_word_t;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [31:0] p2_p3;
        logic [31:0] p4_p5;
        logic [31:0] p6_p7;
        logic [31:0] p8_p9;
    } cal_t;

    // travels alongside the divider
    typedef struct packed {
        logic signed [7:0] temp_deg;
        logic              div_zero;
        logic              p_msb;
    } div_side_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] den;
        div_side_t   side;
    } div_stage_t;

    function automatic logic signed [31:0] sx16(input logic [15:0] x);
        return 32'(signed'(x));
    endfunction

    // signed divide by 2^k, truncating toward zero
    function automatic logic signed [31:0] div_tz(input logic signed [31:0] x, input int k);
        logic signed [31:0] bias;
        bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
        return (x + bias) >>> k;
    endfunction

endpackage

// ===== rtl/baro_temp_press_compensation.sv =====
// Top level: barometric temperature and pressure compensation pipeline.
//
// Takes one raw 20-bit temperature/pressure word per cycle and returns the
// compensated temperature (whole degrees C, saturated to int8) and pressure
// (whole hPa, saturated to 16 bits) computed with the 32-bit integer
// compensation polynomials and the calibration registers. The pipe holds
// 11 front stages for the temperature and pressure polynomials, 32 stages
// of the bit-per-stage pressure divider, and 6 back stages for the
// correction terms and the divide by 100 (a reciprocal multiply).
// Throughput is one word per cycle while the output is not stalled;
// the whole pipe advances whenever the output register is empty or taken,
// so s_ready follows m_ready or an empty output. A zero pressure divisor
// forces press_hpa to 0 and sets div_zero; temp_deg is still valid.
// Calibration words are written through cfg_we/cfg_index/cfg_wdata; the
// user must write them only while the pipe is idle, the block does not
// enforce this. Indexes 0..7 select t1, t2, t3, p1, p2_p3, p4_p5, p6_p7,
// p8_p9, others ignored; 16-bit registers keep the low half of the data.
module baro_temp_press_compensation (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  btpc_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output btpc_pkg::out_word_t m_data,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_index,
    input  logic [31:0]         cfg_wdata
);
    import btpc_pkg::*;

    cal_t cal_reg;
    logic en;
    logic f_valid, d_valid;
    div_stage_t f_stage, d_stage;

    // single pipe enable: stall only when the output word is held
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg.t1    <= 16'd28800;
            cal_reg.t2    <= 16'd26435;
            cal_reg.t3    <= 16'hFC18;  // -1000
            cal_reg.p1    <= '0;
            cal_reg.p2_p3 <= '0;
            cal_reg.p4_p5 <= '0;
            cal_reg.p6_p7 <= '0;
            cal_reg.p8_p9 <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_T1:    cal_reg.t1    <= cfg_wdata[15:0];
                CFG_T2:    cal_reg.t2    <= cfg_wdata[15:0];
                CFG_T3:    cal_reg.t3    <= cfg_wdata[15:0];
                CFG_P1:    cal_reg.p1    <= cfg_wdata[15:0];
                CFG_P2_P3: cal_reg.p2_p3 <= cfg_wdata;
                CFG_P4_P5: cal_reg.p4_p5 <= cfg_wdata;
                CFG_P6_P7: cal_reg.p6_p7 <= cfg_wdata;
                CFG_P8_P9: cal_reg.p8_p9 <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    btpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cal       (cal_reg),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (f_valid),
        .out_stage (f_stage)
    );

    btpc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_stage  (f_stage),
        .out_valid (d_valid),
        .out_stage (d_stage)
    );

    btpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cal       (cal_reg),
        .in_valid  (d_valid),
        .in_stage  (d_stage),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    // a flagged divide always reports zero pressure
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.div_zero |-> m_data.press_hpa == 16'd0)
        else $error("div_zero set with nonzero pressure");

    // input side is open exactly when the output word can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (m_ready || !m_valid))
        else $error("s_ready does not follow output stall");

    // a held output word is still there next cycle
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word lost during stall");
endmodule

// ===== rtl/btpc_front.sv =====
// Front pipeline: temperature polynomial, pressure divisor and dividend.
module btpc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  btpc_pkg::cal_t     cal,
    input  logic               in_valid,
    input  btpc_pkg::in_word_t in_data,
    output logic               out_valid,
    output btpc_pkg::div_stage_t out_stage
);
    import btpc_pkg::*;

    logic [10:0] v_reg;

    logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
    assign t1 = 32'(signed'({1'b0, cal.t1}));
    assign t2 = sx16(cal.t2);
    assign t3 = sx16(cal.t3);
    assign p1 = 32'(signed'({1'b0, cal.p1}));
    assign p2 = sx16(cal.p2_p3[15:0]);
    assign p3 = sx16(cal.p2_p3[31:16]);
    assign p4 = sx16(cal.p4_p5[15:0]);
    assign p5 = sx16(cal.p4_p5[31:16]);
    assign p6 = sx16(cal.p6_p7[15:0]);

    // stage registers
    logic signed [31:0] a_reg, b_reg, m1_reg, m2_reg, v1t_reg, m3_reg, tf_reg;
    logic signed [31:0] tx_reg, pv_reg, mq_reg, mq2_reg, m5_reg, m2p_reg;
    logic signed [31:0] m6_reg, m3p_reg, m5b_reg, m2pb_reg, pv2_reg, pv1_reg;
    logic signed [31:0] m1p_reg, pp_sub_reg, d_reg, pm_reg;
    logic [55:0]        tprod_reg;
    logic               tneg_reg;
    logic [19:0]        pp_reg [1:8];
    logic signed [7:0]  tdeg_reg [7:10];

    // combinational helpers
    logic signed [31:0] tx_c, tmag_c, pv_c, q_c, q2_c, v2_c, v1_c, pm_c, d_c;
    logic [18:0]        tq_c;
    logic signed [7:0]  tdeg_c;

    always_comb begin
        tx_c   = (tf_reg * 32'sd5 + 32'sd128) >>> 8;
        pv_c   = div_tz(tf_reg, 1) - 32'sd64000;
        tmag_c = tx_reg[31] ? -tx_reg : tx_reg;
        q_c    = div_tz(pv_reg, 2);
        q2_c   = pv_reg >>> 2;
        tq_c   = tprod_reg[Recip100Shift +: 19];
        if (!tneg_reg) begin
            tdeg_c = (tq_c > 19'd127) ? 8'sd127 : 8'(tq_c);
        end else begin
            tdeg_c = (tq_c > 19'd128) ? -8'sd128 : 8'(-tq_c);
        end
        v2_c = ((m6_reg + (m5b_reg <<< 1)) >>> 2) + (p4 <<< 16);
        v1_c = ((m3p_reg >>> 3) + (m2pb_reg >>> 1)) >>> 18;
        pm_c = pp_sub_reg * 32'sd3125;
        d_c  = m1p_reg >>> 15;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[9:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // S1
            a_reg     <= 32'(signed'({1'b0, in_data.raw_temp >> 3})) - (t1 <<< 1);
            b_reg     <= 32'(signed'({1'b0, in_data.raw_temp >> 4})) - t1;
            pp_reg[1] <= in_data.raw_press;
            for (int i = 2; i <= 8; i++) pp_reg[i] <= pp_reg[i-1];
            // S2
            m1_reg <= a_reg * t2;
            m2_reg <= b_reg * b_reg;
            // S3
            v1t_reg <= m1_reg >>> 11;
            m3_reg  <= (m2_reg >>> 12) * t3;
            // S4
            tf_reg <= v1t_reg + (m3_reg >>> 14);
            // S5
            tx_reg <= tx_c;
            pv_reg <= pv_c;
            // S6
            tprod_reg <= 56'(tmag_c[23:0]) * 56'(Recip100);
            tneg_reg  <= tx_reg[31];
            mq_reg    <= q_c * q_c;
            mq2_reg   <= q2_c * q2_c;
            m5_reg    <= pv_reg * p5;
            m2p_reg   <= p2 * pv_reg;
            // S7
            tdeg_reg[7] <= tdeg_c;
            m6_reg      <= div_tz(mq_reg, 11) * p6;
            m3p_reg     <= p3 * (mq2_reg >>> 13);
            m5b_reg     <= m5_reg;
            m2pb_reg    <= m2p_reg;
            // S8
            tdeg_reg[8] <= tdeg_reg[7];
            pv2_reg     <= v2_c;
            pv1_reg     <= v1_c;
            // S9
            tdeg_reg[9] <= tdeg_reg[8];
            m1p_reg     <= (32'sd32768 + pv1_reg) * p1;
            pp_sub_reg  <= 32'sd1048576 - 32'(signed'({1'b0, pp_reg[8]})) - (pv2_reg >>> 12);
            // S10
            tdeg_reg[10] <= tdeg_reg[9];
            d_reg        <= d_c;
            pm_reg       <= pm_c;
            // S11: divider input
            out_stage.rem           <= '0;
            out_stage.num           <= pm_reg[31] ? pm_reg : (pm_reg <<< 1);
            out_stage.den           <= d_reg;
            out_stage.side.temp_deg <= tdeg_reg[10];
            out_stage.side.div_zero <= (d_reg == 32'sd0);
            out_stage.side.p_msb    <= pm_reg[31];
        end
    end

    assign out_valid = v_reg[10];
endmodule

// ===== rtl/btpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module btpc_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  btpc_pkg::div_stage_t  in_stage,
    output logic                  out_valid,
    output btpc_pkg::div_stage_t  out_stage
);
    import btpc_pkg::*;

    div_stage_t st_reg [DivBits];
    logic [DivBits-1:0] v_reg;

    function automatic div_stage_t step(input div_stage_t s);
        div_stage_t r;
        logic [32:0] part;
        logic [32:0] diff;
        r    = s;
        part = {s.rem, s.num[31]};
        diff = part - {1'b0, s.den};
        r.num = {s.num[30:0], ~diff[32]};
        r.rem = diff[32] ? part[31:0] : diff[31:0];
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[DivBits-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= step(in_stage);
            for (int i = 1; i < DivBits; i++) st_reg[i] <= step(st_reg[i-1]);
        end
    end

    assign out_valid = v_reg[DivBits-1];
    assign out_stage = st_reg[DivBits-1];
endmodule

// ===== rtl/btpc_back.sv =====
// Back pipeline: pressure correction terms, divide by 100, saturation, output register.
module btpc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  btpc_pkg::cal_t       cal,
    input  logic                 in_valid,
    input  btpc_pkg::div_stage_t in_stage,
    output logic                 out_valid,
    output btpc_pkg::out_word_t  out_data
);
    import btpc_pkg::*;

    logic [5:0] v_reg;
    logic signed [31:0] p7, p8, p9;
    assign p7 = sx16(cal.p6_p7[31:16]);
    assign p8 = sx16(cal.p8_p9[15:0]);
    assign p9 = sx16(cal.p8_p9[31:16]);

    div_side_t side_reg [0:4];
    logic signed [31:0] p_reg [0:2];
    logic [31:0]        sq_reg;
    logic signed [31:0] m8_reg, c1_reg, c2_reg, pf_reg;
    logic [63:0]        pmul_reg;

    logic [57:0] sqp_c;
    logic [26:0] pq_c;
    assign sqp_c = 58'(p_reg[0][31:3]) * 58'(p_reg[0][31:3]);
    assign pq_c  = pmul_reg[Recip100Shift +: 27];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_stage.side;
            for (int i = 1; i <= 4; i++) side_reg[i] <= side_reg[i-1];
            p_reg[0] <= in_stage.side.p_msb ? (in_stage.num <<< 1) : in_stage.num;
            p_reg[1] <= p_reg[0];
            p_reg[2] <= p_reg[1];
            sq_reg   <= 32'(sqp_c[31:0] >> 13);
            m8_reg   <= div_tz(p_reg[0], 2) * p8;
            c1_reg   <= (p9 * signed'(sq_reg)) >>> 12;
            c2_reg   <= div_tz(m8_reg, 13);
            pf_reg   <= p_reg[2] + ((c1_reg + c2_reg + p7) >>> 4);
            // pressure is unsigned here
            pmul_reg <= {32'd0, pf_reg} * 64'(Recip100);
            out_data.temp_deg  <= side_reg[4].temp_deg;
            out_data.div_zero  <= side_reg[4].div_zero;
            out_data.press_hpa <= side_reg[4].div_zero ? 16'd0 :
                                  (pq_c > 27'd65535) ? 16'hFFFF : pq_c[15:0];
        end
    end

    assign out_valid = v_reg[5];
endmodule

// ===== tb/sv/baro_temp_press_compensation_tb.sv =====
// Testbench for the barometric temperature and pressure compensation block.
`timescale 1ns / 1ps

module baro_temp_press_compensation_tb;
    import btpc_pkg::*;

    localparam int PipeDepth = 49;
    localparam int StallLimit = 20000;      // cycles with no handshake or config write

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_word_t   m_data;
    logic        cfg_we;
    logic [3:0]  cfg_index;
    logic [31:0] cfg_wdata;

    baro_temp_press_compensation dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // shadow copy of the calibration registers
    cal_t cal;

    out_word_t pending_words[$];
    int  fail_count;
    int  word_count;
    int  result_count;
    int  zero_div_count;
    int  sat_count;
    int  idle_pct;       // percent of cycles each side idles
    int  quiet_cycles;
    bit  stim_done;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Compensation predictor: 32-bit wrapping two's complement math.
    // ---------------------------------------------------------------
    function automatic logic signed [31:0] ext16(input logic [15:0] x);
        ext16 = {{16{x[15]}}, x};
    endfunction

    function automatic out_word_t compensate(input in_word_t w);
        logic signed [31:0] tt, pp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [31:0] a, b, tfine, temp, v1, v2, q;
        logic [31:0] p, press, d, sq;
        out_word_t r;
        tt = {12'd0, w.raw_temp};
        pp = {12'd0, w.raw_press};
        t1 = {16'd0, cal.t1};
        t2 = ext16(cal.t2);
        t3 = ext16(cal.t3);
        p1 = {16'd0, cal.p1};
        p2 = ext16(cal.p2_p3[15:0]);  p3 = ext16(cal.p2_p3[31:16]);
        p4 = ext16(cal.p4_p5[15:0]);  p5 = ext16(cal.p4_p5[31:16]);
        p6 = ext16(cal.p6_p7[15:0]);  p7 = ext16(cal.p6_p7[31:16]);
        p8 = ext16(cal.p8_p9[15:0]);  p9 = ext16(cal.p8_p9[31:16]);

        // temperature
        a = (tt >>> 3) - t1 * 2;
        v1 = (a * t2) >>> 11;
        b = (tt >>> 4) - t1;
        v2 = (((b * b) >>> 12) * t3) >>> 14;
        tfine = v1 + v2;
        temp = ((tfine * 5 + 128) >>> 8) / 100;
        if (temp > 127) temp = 127;
        if (temp < -128) temp = -128;

        // pressure
        v1 = tfine / 2 - 64000;
        q = v1 / 4;
        v2 = ((q * q) / 2048) * p6;
        v2 = v2 + ((v1 * p5) <<< 1);
        v2 = (v2 >>> 2) + (p4 <<< 16);
        q = v1 >>> 2;
        v1 = (((p3 * ((q * q) >>> 13)) >>> 3) + ((p2 * v1) >>> 1)) >>> 18;
        v1 = ((32'sd32768 + v1) * p1) >>> 15;
        // arithmetic shift kept out of the unsigned expression
        q = v2 >>> 12;
        p = ((32'd1048576 - pp) - q) * 32'd3125;
        r.temp_deg = temp[7:0];
        if (v1 == 0) begin
            r.div_zero = 1'b1;
            r.press_hpa = '0;
        end else begin
            d = v1;
            if (p < 32'h80000000) p = (p << 1) / d;
            else p = (p / d) * 32'd2;
            sq = ((p >> 3) * (p >> 3)) >> 13;
            v1 = (p9 * signed'(sq)) >>> 12;
            v2 = ((signed'(p) / 4) * p8) / 8192;
            p = signed'(p) + (((v1 + v2) + p7) >>> 4);
            press = p / 32'd100;
            if (press > 65535) press = 65535;
            r.div_zero = 1'b0;
            r.press_hpa = press[15:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Register writes (pipe idle only) and word transmit
    // ---------------------------------------------------------------
    task automatic write_cal(input logic [3:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_T1:    cal.t1 = val[15:0];
            CFG_T2:    cal.t2 = val[15:0];
            CFG_T3:    cal.t3 = val[15:0];
            CFG_P1:    cal.p1 = val[15:0];
            CFG_P2_P3: cal.p2_p3 = val;
            CFG_P4_P5: cal.p4_p5 = val;
            CFG_P6_P7: cal.p6_p7 = val;
            CFG_P8_P9: cal.p8_p9 = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic write_all(input logic [15:0] t1, input logic [15:0] t2,
                             input logic [15:0] t3, input logic [15:0] p1,
                             input logic [31:0] p23, input logic [31:0] p45,
                             input logic [31:0] p67, input logic [31:0] p89);
        write_cal(CFG_T1, {16'hDEAD, t1});   // upper half must be dropped
        write_cal(CFG_T2, {16'hBEEF, t2});
        write_cal(CFG_T3, {16'h0000, t3});
        write_cal(CFG_P1, {16'hFFFF, p1});
        write_cal(CFG_P2_P3, p23);
        write_cal(CFG_P4_P5, p45);
        write_cal(CFG_P6_P7, p67);
        write_cal(CFG_P8_P9, p89);
        write_cal(4'hF, 32'hFFFFFFFF);       // out-of-range index: ignored
        cfg_we <= 1'b0;
    endtask

    // wait for every expected word, then the drain time of the pipe
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (PipeDepth + 4) @(posedge aclk);
    endtask

    task automatic send_word(input logic [19:0] rt, input logic [19:0] rp);
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{raw_temp: rt, raw_press: rp};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_words.push_back(compensate(s_data));
        word_count++;
    endtask

    // sink side: random backpressure
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= (idle_pct == 0) || ($urandom_range(99, 0) >= idle_pct);
    end

    // checker: compares each result word to the oldest prediction
    always @(posedge aclk) begin
        out_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_data);
                fail_count++;
            end else begin
                exp_w = pending_words.pop_front();
                if (exp_w.div_zero) zero_div_count++;
                if (exp_w.press_hpa == 16'hFFFF || exp_w.temp_deg == 8'sd127 ||
                    exp_w.temp_deg == -8'sd128) sat_count++;
                if (m_data.temp_deg !== exp_w.temp_deg) begin
                    $display("%0t: temp_deg expected %0d actual %0d", $time,
                             exp_w.temp_deg, m_data.temp_deg);
                    fail_count++;
                end
                if (m_data.press_hpa !== exp_w.press_hpa) begin
                    $display("%0t: press_hpa expected %0d actual %0d", $time,
                             exp_w.press_hpa, m_data.press_hpa);
                    fail_count++;
                end
                if (m_data.div_zero !== exp_w.div_zero) begin
                    $display("%0t: div_zero expected %0b actual %0b", $time,
                             exp_w.div_zero, m_data.div_zero);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: any handshake or config write resets the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            quiet_cycles <= 0;
        else if (stim_done && pending_words.size() == 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("watchdog: no progress, %0d words outstanding",
                     pending_words.size());
            $display("baro_temp_press_compensation_tb: FAIL");
            $finish;
        end
    end

    // typical sensor calibration set, p1 nonzero so divisions happen
    task automatic load_typical();
        write_all(16'd27504, 16'd26435, -16'sd1000, 16'd36477,
                  {-16'sd5, -16'sd10685}, {16'sd140, 16'sd2855},
                  {16'sd15500, -16'sd7}, {16'sd6000, -16'sd14600});
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // reset values: p1 == 0 so every word hits the zero divisor case
    task automatic test_reset_defaults();
        send_word(20'd0, 20'd0);
        send_word(20'hFFFFF, 20'hFFFFF);
        send_word(20'd519888, 20'd415148);
        drain();
    endtask

    // field extremes and saturation under typical and extreme calibration
    task automatic test_directed_extremes();
        load_typical();
        send_word(20'd519888, 20'd415148);
        send_word(20'd0, 20'd0);
        send_word(20'hFFFFF, 20'hFFFFF);
        send_word(20'd0, 20'hFFFFF);
        send_word(20'hFFFFF, 20'd0);
        send_word(20'hAAAAA, 20'h55555);
        send_word(20'h55555, 20'hAAAAA);
        drain();
        // extreme words: temperature saturates negative for raw 0x80000
        write_all(16'hFFFF, 16'h7FFF, 16'h8000, 16'd1,
                  32'h7FFF8000, 32'h80007FFF, 32'h7FFF7FFF, 32'h80008000);
        send_word(20'd0, 20'd0);
        send_word(20'hFFFFF, 20'hFFFFF);
        send_word(20'h80000, 20'h00001);
        drain();
        write_all(16'd0, 16'h8000, 16'h7FFF, 16'hFFFF,
                  32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000);
        send_word(20'd0, 20'd0);
        send_word(20'hFFFFF, 20'hFFFFF);
        send_word(20'h12345, 20'hFEDCB);
        drain();
    endtask

    // random raw words under a given calibration, no idling for a while too
    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) send_word(20'($urandom), 20'($urandom));
    endtask

    task automatic test_random_cal();
        for (int k = 0; k < 6; k++) begin
            if (k == 0) load_typical();
            else write_all(16'($urandom), 16'($urandom), 16'($urandom),
                           ($urandom_range(3, 0) == 0) ? 16'd0 : 16'($urandom),
                           $urandom, $urandom, $urandom, $urandom);
            idle_pct = (k == 2) ? 0 : 23;
            run_random(k == 0 ? 700 : 230);
            drain();
        end
    endtask

    // sender pauses mid-stream until every prediction has been matched
    task automatic test_pause_until_empty();
        load_typical();
        idle_pct = 23;
        run_random(20);
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        run_random(20);
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        fail_count = 0;
        word_count = 0;
        result_count = 0;
        zero_div_count = 0;
        sat_count = 0;
        idle_pct = 23;
        stim_done = 1'b0;
        cal = '{t1: 16'd28800, t2: 16'd26435, t3: -16'sd1000, default: '0};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_directed_extremes();
        test_random_cal();
        test_pause_until_empty();

        stim_done = 1'b1;
        drain();
        if (pending_words.size() != 0) fail_count++;
        $display("Sent %0d words, checked %0d results (%0d zero divisor, %0d saturated)",
                 word_count, result_count, zero_div_count, sat_count);
        $display("across reset, typical, extreme and random calibration sets.");
        if (fail_count == 0)
            $display("baro_temp_press_compensation_tb: PASS");
        else
            $display("baro_temp_press_compensation_tb: FAIL");
        $finish;
    end

endmodule
